[src/star_polygon_vertex_generator_unit_assert.svh]
// Assertion macros shared by the star polygon vertex generator modules.
`ifndef STAR_POLYGON_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`define STAR_POLYGON_VERTEX_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPVG_ASSERT_HOLDS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPVG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/spvg_pkg.sv]
// Shared widths, constants and engine interface types for the star vertex generator.
package spvg_pkg;

  localparam int COORD_W        = 32;
  localparam int PC_W           = 6;
  localparam int MIN_SIDES      = 3;
  localparam int MAX_POINTS_DEF = 32;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int PHASE_W        = 32;
  localparam int MUL_W          = 33;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int TRIG_W         = 16;

  // 0.001 in Q16.16
  localparam logic signed [COORD_W-1:0] MIN_OUTER = COORD_W'(66);

  typedef struct packed {
    logic                      start;
    logic [PHASE_W-1:0]        phase;
    logic signed [COORD_W-1:0] radius;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } vtx_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
  } vtx_rsp_t;

endpackage

[src/spvg_mul.sv]
// Shared unsigned multiplier with registered product.
module spvg_mul
  import spvg_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

[src/spvg_engine.sv]
// Vertex engine: polynomial sine/cosine and placement on one shared multiplier.
module spvg_engine
  import spvg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  vtx_req_t req,
  output vtx_rsp_t rsp
);

  `include "star_polygon_vertex_generator_unit_assert.svh"

  // 2*pi in Q32 = 6 * 2^32 + TwoPiLo
  localparam logic [31:0] TwoPiLo = 32'd1216271633;

  localparam logic [31:0] Recip42 = 32'((64'd1 << 34) / 42);
  localparam logic [31:0] Recip20 = 32'((64'd1 << 34) / 20);
  localparam logic [31:0] Recip6  = 32'((64'd1 << 34) / 6);
  localparam logic [31:0] Recip56 = 32'((64'd1 << 34) / 56);
  localparam logic [31:0] Recip30 = 32'((64'd1 << 34) / 30);
  localparam logic [31:0] Recip12 = 32'((64'd1 << 34) / 12);

  localparam int MAG_W  = COORD_W - 1 + TRIG_W;
  localparam int VAL_W  = MAG_W + 3;
  localparam int OFFS_W = VAL_W - 15;
  localparam int SUM_W  = OFFS_W + 1;

  localparam logic signed [SUM_W-1:0] CoordMax =
    SUM_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] CoordMin = SUM_W'(-(64'sd1 <<< (COORD_W - 1)));

  typedef enum logic [2:0] {
    TERM_S42, TERM_S20, TERM_S6, TERM_C56, TERM_C30, TERM_C12, TERM_C2
  } term_t;

  typedef enum logic [15:0] {
    E_IDLE = 16'b0000_0000_0000_0001,
    E_MX   = 16'b0000_0000_0000_0010,
    E_X    = 16'b0000_0000_0000_0100,
    E_MX2  = 16'b0000_0000_0000_1000,
    E_X2   = 16'b0000_0000_0001_0000,
    E_DB   = 16'b0000_0000_0010_0000,
    E_DD   = 16'b0000_0000_0100_0000,
    E_MT   = 16'b0000_0000_1000_0000,
    E_DA   = 16'b0000_0001_0000_0000,
    E_MS   = 16'b0000_0010_0000_0000,
    E_SV   = 16'b0000_0100_0000_0000,
    E_CF   = 16'b0000_1000_0000_0000,
    E_PX   = 16'b0001_0000_0000_0000,
    E_PY   = 16'b0010_0000_0000_0000,
    E_OY   = 16'b0100_0000_0000_0000,
    E_AY   = 16'b1000_0000_0000_0000
  } eng_state_t;

  function automatic logic [5:0] div_of(term_t t);
    logic [5:0] d;
    unique case (t)
      TERM_S42: d = 6'd42;
      TERM_S20: d = 6'd20;
      TERM_S6:  d = 6'd6;
      TERM_C56: d = 6'd56;
      TERM_C30: d = 6'd30;
      TERM_C12: d = 6'd12;
      default:  d = 6'd2;
    endcase
    return d;
  endfunction

  function automatic logic [31:0] recip_of(term_t t);
    logic [31:0] m;
    unique case (t)
      TERM_S42: m = Recip42;
      TERM_S20: m = Recip20;
      TERM_S6:  m = Recip6;
      TERM_C56: m = Recip56;
      TERM_C30: m = Recip30;
      TERM_C12: m = Recip12;
      default:  m = '0;
    endcase
    return m;
  endfunction

  // radius * trig + 0.5 at 2^-15, floor
  function automatic logic signed [OFFS_W-1:0] offset_of(logic [MAG_W-1:0] mag, logic neg);
    logic signed [VAL_W-1:0] m;
    logic signed [VAL_W-1:0] val;
    m   = signed'({3'b000, mag});
    val = neg ? (VAL_W'(16384) - m) : (m + VAL_W'(16384));
    return OFFS_W'(val >>> 15);
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_add(logic signed [COORD_W-1:0] c,
                                                        logic signed [OFFS_W-1:0] o);
    logic signed [SUM_W-1:0] s;
    logic signed [COORD_W-1:0] r;
    s = SUM_W'(c) + SUM_W'(o);
    if (s > CoordMax) begin
      r = COORD_W'(CoordMax);
    end else if (s < CoordMin) begin
      r = COORD_W'(CoordMin);
    end else begin
      r = COORD_W'(s);
    end
    return r;
  endfunction

  eng_state_t state_r, state_nxt;
  term_t      term_r, term_nxt;

  logic [1:0]  quad_r;
  logic        swap_r;
  logic [29:0] r_r;
  logic [31:0] r6_r;
  logic [31:0] x_r;
  logic [31:0] x2_r;
  logic [31:0] v_r;
  logic [29:0] q0_r;
  logic [32:0] t_r;
  logic [TRIG_W-1:0] s0_r;
  logic [TRIG_W-1:0] c0_r;
  logic signed [OFFS_W-1:0] offx_r;
  logic signed [OFFS_W-1:0] offy_r;
  logic signed [COORD_W-1:0] vx_r;
  logic signed [COORD_W-1:0] vy_r;

  logic [MUL_W-1:0]  op_a, op_b;
  logic [PROD_W-1:0] prod;

  logic [29:0] fold_r;
  logic        fold_swap;
  logic [30:0] fold_mirror;
  logic [31:0] rem;
  logic [31:0] quot;
  logic [32:0] sv_rnd;
  logic [32:0] cv;
  logic [33:0] cv_rnd;
  logic [TRIG_W-1:0] sw_s, sw_c;
  logic [TRIG_W-1:0] cos_mag, sin_mag;
  logic cos_neg, sin_neg;

  spvg_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod)
  );

  always_comb begin
    fold_r      = req.phase[29:0];
    fold_swap   = fold_r > 30'h2000_0000;
    fold_mirror = 31'h4000_0000 - 31'(fold_r);

    rem    = v_r - prod[31:0];
    quot   = (rem >= 32'(div_of(term_r))) ? 32'(q0_r) + 32'd1 : 32'(q0_r);
    sv_rnd = 33'(prod[63:32]) + 33'h1_0000;
    cv     = 33'h1_0000_0000 - 33'(prod[63:33]);
    cv_rnd = 34'(cv) + 34'h1_0000;

    sw_s    = swap_r ? c0_r : s0_r;
    sw_c    = swap_r ? s0_r : c0_r;
    cos_mag = quad_r[0] ? sw_s : sw_c;
    sin_mag = quad_r[0] ? sw_c : sw_s;
    cos_neg = quad_r[0] ^ quad_r[1];
    sin_neg = quad_r[1];
  end

  // multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      E_MX: begin
        op_a = MUL_W'(r_r);
        op_b = MUL_W'(TwoPiLo);
      end
      E_MX2: begin
        op_a = MUL_W'(x_r);
        op_b = MUL_W'(x_r);
      end
      E_X2, E_DA: begin
        op_a = MUL_W'(prod[63:32]);
        op_b = MUL_W'(recip_of(term_r));
      end
      E_SV: begin
        op_a = MUL_W'(x2_r);
        op_b = MUL_W'(recip_of(term_r));
      end
      E_DB: begin
        op_a = MUL_W'(prod[63:34]);
        op_b = MUL_W'(div_of(term_r));
      end
      E_MT: begin
        op_a = MUL_W'(x2_r);
        op_b = MUL_W'(t_r);
      end
      E_MS: begin
        op_a = MUL_W'(x_r);
        op_b = MUL_W'(t_r);
      end
      E_PX: begin
        op_a = MUL_W'(req.radius[COORD_W-2:0]);
        op_b = MUL_W'(cos_mag);
      end
      E_PY: begin
        op_a = MUL_W'(req.radius[COORD_W-2:0]);
        op_b = MUL_W'(sin_mag);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    unique case (state_r)
      E_IDLE: begin
        if (req.start) begin
          state_nxt = E_MX;
          term_nxt  = TERM_S42;
        end
      end
      E_MX:  state_nxt = E_X;
      E_X:   state_nxt = E_MX2;
      E_MX2: state_nxt = E_X2;
      E_X2:  state_nxt = E_DB;
      E_DB:  state_nxt = E_DD;
      E_DD: begin
        term_nxt  = term_t'(term_r + 3'd1);
        state_nxt = (term_r == TERM_S6) ? E_MS : E_MT;
      end
      E_MT:  state_nxt = (term_r == TERM_C2) ? E_CF : E_DA;
      E_DA:  state_nxt = E_DB;
      E_MS:  state_nxt = E_SV;
      E_SV:  state_nxt = E_DB;
      E_CF:  state_nxt = E_PX;
      E_PX:  state_nxt = E_PY;
      E_PY:  state_nxt = E_OY;
      E_OY:  state_nxt = E_AY;
      E_AY:  state_nxt = E_IDLE;
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      term_r  <= TERM_S42;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      E_IDLE: begin
        if (req.start) begin
          quad_r <= req.phase[31:30];
          swap_r <= fold_swap;
          r_r    <= fold_swap ? fold_mirror[29:0] : fold_r;
        end
      end
      E_MX: r6_r <= 32'({r_r, 2'b00}) + 32'({r_r, 1'b0});
      E_X:  x_r  <= prod[63:32] + r6_r;
      E_X2: begin
        x2_r <= prod[63:32];
        v_r  <= prod[63:32];
      end
      E_DB: q0_r <= prod[63:34];
      E_DD: t_r  <= 33'h1_0000_0000 - 33'(quot);
      E_DA: v_r  <= prod[63:32];
      E_SV: begin
        s0_r <= sv_rnd[32:17];
        v_r  <= x2_r;
      end
      E_CF: c0_r <= cv_rnd[32:17];
      E_PY: offx_r <= offset_of(prod[MAG_W-1:0], cos_neg);
      E_OY: begin
        offy_r <= offset_of(prod[MAG_W-1:0], sin_neg);
        vx_r   <= sat_add(req.cx, offx_r);
      end
      E_AY: vy_r <= sat_add(req.cy, offy_r);
      default: ;
    endcase
  end

  assign rsp.busy = (state_r != E_IDLE);
  assign rsp.done = (state_r == E_AY);
  assign rsp.vx   = vx_r;
  assign rsp.vy   = vy_r;

  `SPVG_ASSERT_HOLDS(a_start_when_idle, req.start, state_r == E_IDLE, "vertex start while engine busy")
  `SPVG_ASSERT_HOLDS(a_cos_chain_done, state_r == E_CF, term_r == TERM_C2, "cosine finish before last term")

endmodule

[src/star_polygon_vertex_generator_unit.sv]
// Top level of the star polygon vertex generator: input capture, vertex walk, output register.
//
//   Channel  Ports                     Transaction
//   input    in_tvalid/in_tready       one star description (in_tdata)
//   output   out_tvalid/out_tready     one vertex (out_tdata, out_tuser, out_tlast)
//
// A star with N points (after clamping) gives 2*N vertices, outer then inner per point.
// Each vertex passes through an issue state, the vertex engine and a load of the output register;
// the next vertex is issued only after the last one has been loaded, so vertices do not overlap.
// The pace is set by the single shared 33x33 multiplier, used 22 times per vertex.
// in_tready is high only between stars; a stalled output holds the walk at the next vertex.
// rst_n is synchronous and active low; no clearing pass is needed after reset.
module star_polygon_vertex_generator_unit
  import spvg_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  localparam int IN_FIELDS_W = PC_W + 4 * COORD_W + 2 * ANGLE_BITS,
  localparam int IN_W = ((IN_FIELDS_W + 7) / 8) * 8,
  localparam int OUT_W = 2 * COORD_W
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // point_count, center_x, center_y, outer_radius, inner_radius, outer_angle, inner_angle
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // vertex_x, vertex_y
  output logic [OUT_W-1:0] out_tdata,
  // is_line
  output logic             out_tuser,
  output logic             out_tlast
);

  `include "star_polygon_vertex_generator_unit_assert.svh"

  localparam int SIDE_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W  = SIDE_W + 1;

  localparam int CxLo = PC_W;
  localparam int CyLo = CxLo + COORD_W;
  localparam int R1Lo = CyLo + COORD_W;
  localparam int R2Lo = R1Lo + COORD_W;
  localparam int OaLo = R2Lo + COORD_W;
  localparam int IaLo = OaLo + ANGLE_BITS;

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_ISSUE = 4'b0010,
    T_WAIT  = 4'b0100,
    T_OUT   = 4'b1000
  } top_state_t;

  top_state_t state_r, state_nxt;

  logic [IDX_W-1:0]          idx_r;
  logic [SIDE_W-1:0]         sides_r;
  logic [ANGLE_BITS-1:0]     step_r;
  logic [ANGLE_BITS-1:0]     acc_o_r;
  logic [ANGLE_BITS-1:0]     acc_i_r;
  logic signed [COORD_W-1:0] cx_r, cy_r, r1_r, r2_r;

  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r, out_y_r;
  logic                      out_line_r, out_last_r;

  logic [ANGLE_BITS-1:0] step_tab [MAX_POINTS+1];

  logic [PC_W-1:0]           pc_in;
  logic signed [COORD_W-1:0] cx_in, cy_in, r1_in, r2_in, r1_c, r2_c;
  logic [ANGLE_BITS-1:0]     oa_in, ia_in;
  logic [6:0]                pc7, sides7;
  logic [SIDE_W-1:0]         sides_c;
  logic [IDX_W-1:0]          total;
  logic                      pass, last_vtx, in_acc, out_free, out_load;
  logic [ANGLE_BITS-1:0]     ang;

  vtx_req_t req;
  vtx_rsp_t rsp;

  // rounded angle step per side count, worked out at elaboration
  for (genvar g = 0; g <= MAX_POINTS; g++) begin : g_step
    if (g < MIN_SIDES) begin : g_unused
      assign step_tab[g] = '0;
    end else begin : g_val
      localparam longint unsigned StepVal = ((64'd1 << ANGLE_BITS) + g / 2) / g;
      assign step_tab[g] = ANGLE_BITS'(StepVal);
    end
  end

  always_comb begin
    pc_in = in_tdata[PC_W-1:0];
    cx_in = signed'(in_tdata[CxLo +: COORD_W]);
    cy_in = signed'(in_tdata[CyLo +: COORD_W]);
    r1_in = signed'(in_tdata[R1Lo +: COORD_W]);
    r2_in = signed'(in_tdata[R2Lo +: COORD_W]);
    oa_in = in_tdata[OaLo +: ANGLE_BITS];
    ia_in = in_tdata[IaLo +: ANGLE_BITS];

    pc7 = 7'(pc_in);
    if (pc7 < 7'(MIN_SIDES)) begin
      sides7 = 7'(MIN_SIDES);
    end else if (pc7 > 7'(MAX_POINTS)) begin
      sides7 = 7'(MAX_POINTS);
    end else begin
      sides7 = pc7;
    end
    sides_c = SIDE_W'(sides7);

    r1_c = (r1_in < MIN_OUTER) ? MIN_OUTER : r1_in;
    if (r2_in < 0) begin
      r2_c = '0;
    end else if (r2_in > r1_c) begin
      r2_c = r1_c;
    end else begin
      r2_c = r2_in;
    end
  end

  assign in_tready = (state_r == T_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign out_load  = (state_r == T_OUT) && out_free;

  assign total    = {sides_r, 1'b0};
  assign pass     = idx_r[0];
  assign last_vtx = (idx_r == total - IDX_W'(1));
  assign ang      = pass ? acc_i_r : acc_o_r;

  assign req.start  = (state_r == T_ISSUE);
  assign req.phase  = PHASE_W'(ang) << (PHASE_W - ANGLE_BITS);
  assign req.radius = pass ? r2_r : r1_r;
  assign req.cx     = cx_r;
  assign req.cy     = cy_r;

  spvg_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE:  if (in_acc) state_nxt = T_ISSUE;
      T_ISSUE: state_nxt = T_WAIT;
      T_WAIT:  if (rsp.done) state_nxt = T_OUT;
      T_OUT:   if (out_free) state_nxt = last_vtx ? T_IDLE : T_ISSUE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        idx_r <= '0;
      end else if (out_load) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sides_r <= sides_c;
      step_r  <= step_tab[sides_c];
      acc_o_r <= oa_in;
      acc_i_r <= ia_in;
      cx_r    <= cx_in;
      cy_r    <= cy_in;
      r1_r    <= r1_c;
      r2_r    <= r2_c;
    end else if (out_load && pass) begin
      // both start angles advance after the inner vertex of a point
      acc_o_r <= acc_o_r + step_r;
      acc_i_r <= acc_i_r + step_r;
    end
    if (out_load) begin
      out_x_r    <= rsp.vx;
      out_y_r    <= rsp.vy;
      out_line_r <= (idx_r != '0);
      out_last_r <= last_vtx;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_line_r;
  assign out_tlast  = out_last_r;

  `SPVG_ASSERT_HOLDS(a_done_while_waiting, rsp.done, state_r == T_WAIT, "vertex result with nobody waiting")
  `SPVG_ASSERT_NEXT(a_idle_after_last, out_load && last_vtx, state_r == T_IDLE, "star did not end after last vertex")
  `SPVG_ASSERT_HOLDS(a_index_in_range, state_r != T_IDLE, idx_r < total, "vertex index past end of star")
  `SPVG_ASSERT_HOLDS(a_issue_engine_idle, state_r == T_ISSUE, !rsp.busy, "vertex issued to busy engine")

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the star polygon vertex generator: directed table, then random stars.
`timescale 1ns / 100ps

module tb_top;
  import spvg_pkg::*;

  localparam int IN_W        = 168;
  localparam int OUT_W       = 2 * COORD_W;
  localparam int RANDOM_STARS = 200;
  localparam int QUIET_FROM  = 170;   // no idling on either side from this star on
  localparam int STALL_LIMIT = 5000;  // cycles with no transaction on either side
  localparam int TAIL_CYCLES = 100;

  localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;
  localparam logic [63:0] ONE_Q32    = 64'd4294967296;

  typedef enum logic [1:0] {QUAD_FIRST, QUAD_SECOND, QUAD_THIRD, QUAD_FOURTH} quadrant_t;

  typedef struct packed {
    logic [5:0]  points;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] r_out;
    logic [31:0] r_in;
    logic [15:0] a_out;
    logic [15:0] a_in;
  } star_t;

  typedef struct packed {
    star_t       star;
    logic        check_first;  // first vertex typed in below
    logic        drain;        // wait for all vertices before sending
    logic [31:0] first_x;
    logic [31:0] first_y;
  } star_row_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               line;
    logic               close;
  } vertex_t;

  localparam int N_ROWS = 20;
  localparam star_row_t DIRECTED_STARS [N_ROWS] = '{
    // count 0 -> 3, unit radius at angle zero
    '{'{6'd0, 32'h0, 32'h0, 32'h0001_0000, 32'h0000_8000, 16'h0, 16'h0},
      1'b1, 1'b0, 32'h0001_0000, 32'h0},
    // negative outer radius raised to minimum
    '{'{6'd1, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 16'h0, 16'h0},
      1'b1, 1'b0, 32'd66, 32'h0},
    '{'{6'd2, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_4000, 32'h0000_2000, 16'h1234, 16'h4321},
      1'b0, 1'b0, 32'h0, 32'h0},
    '{'{6'd3, 32'h0, 32'h0, 32'h0010_0000, 32'h0008_0000, 16'h0000, 16'h5555},
      1'b0, 1'b0, 32'h0, 32'h0},
    '{'{6'd32, 32'h0, 32'h0, 32'h0100_0000, 32'h0040_0000, 16'h0, 16'h0400},
      1'b0, 1'b0, 32'h0, 32'h0},
    '{'{6'd33, 32'h1000_0000, 32'hF000_0000, 32'h0001_0000, 32'h0000_1000, 16'h8000, 16'h0},
      1'b0, 1'b0, 32'h0, 32'h0},
    '{'{6'd63, 32'h0, 32'h0, 32'h0000_0100, 32'h0000_0080, 16'hFFFF, 16'h0001},
      1'b0, 1'b0, 32'h0, 32'h0},
    // inner above outer
    '{'{6'd5, 32'h0, 32'h0, 32'h0002_0000, 32'h7FFF_FFFF, 16'h0, 16'h0},
      1'b0, 1'b0, 32'h0, 32'h0},
    // negative inner
    '{'{6'd4, 32'h0, 32'h0, 32'h0002_0000, 32'h8000_0000, 16'h0, 16'h2000},
      1'b0, 1'b0, 32'h0, 32'h0},
    // x saturates high at angle zero
    '{'{6'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0, 16'h0},
      1'b1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000},
    // half turn, x saturates low
    '{'{6'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 16'h8000, 16'h8000},
      1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF},
    // angle wrap
    '{'{6'd7, 32'h0, 32'h0, 32'h0003_0000, 32'h0001_0000, 16'hFFFF, 16'hFFFF},
      1'b0, 1'b0, 32'h0, 32'h0},
    '{'{6'd4, 32'h0, 32'h0, 32'h0001_0000, 32'h0000_8000, 16'h4000, 16'hC000},
      1'b0, 1'b0, 32'h0, 32'h0},
    // octant fold boundary
    '{'{6'd8, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 16'h2000, 16'h2001},
      1'b0, 1'b0, 32'h0, 32'h0},
    '{'{6'd3, 32'h0, 32'h0, 32'd65, 32'd66, 16'h1FFF, 16'h6000},
      1'b0, 1'b0, 32'h0, 32'h0},
    '{'{6'd3, 32'h0, 32'h0, 32'd66, 32'd67, 16'hA000, 16'hE000},
      1'b0, 1'b1, 32'h0, 32'h0},
    '{'{6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF},
      1'b0, 1'b0, 32'h0, 32'h0},
    '{'{6'h15, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h2AAA_AAAA, 16'h5555, 16'hAAAA},
      1'b0, 1'b0, 32'h0, 32'h0},
    '{'{6'h2A, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0AAA_AAAA, 32'h0555_5555, 16'hAAAA, 16'h5555},
      1'b0, 1'b0, 32'h0, 32'h0},
    '{'{6'd5, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0CCC, 16'h3333},
      1'b0, 1'b0, 32'h0, 32'h0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             out_tlast;

  vertex_t pending_vertices[$];
  vertex_t want_vertex;
  int      mismatch_count;
  int      idle_cycles;
  bit      quiet;

  star_polygon_vertex_generator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Q15 sine/cosine of a 32-bit phase, octant fold plus truncated series
  function automatic void sincos_q15(input logic [31:0] phase, output int sn, output int cs);
    quadrant_t   quad;
    logic [63:0] r, x, x2, t, sv, cv;
    bit          swap;
    int          s0, c0, tmp;
    quad = quadrant_t'(phase[31:30]);
    r    = {34'd0, phase[29:0]};
    swap = r > 64'h2000_0000;
    if (swap) r = 64'h4000_0000 - r;
    x  = (r * TWO_PI_Q32) >> 32;
    x2 = (x * x) >> 32;
    t  = ONE_Q32 - x2 / 64'd42;
    t  = ONE_Q32 - ((x2 * t) >> 32) / 64'd20;
    t  = ONE_Q32 - ((x2 * t) >> 32) / 64'd6;
    sv = (x * t) >> 32;
    t  = ONE_Q32 - x2 / 64'd56;
    t  = ONE_Q32 - ((x2 * t) >> 32) / 64'd30;
    t  = ONE_Q32 - ((x2 * t) >> 32) / 64'd12;
    cv = ONE_Q32 - ((x2 * t) >> 32) / 64'd2;
    s0 = int'((sv + 64'h1_0000) >> 17);
    c0 = int'((cv + 64'h1_0000) >> 17);
    if (swap) begin
      tmp = s0;
      s0  = c0;
      c0  = tmp;
    end
    case (quad)
      QUAD_FIRST:  begin sn = s0;  cs = c0;  end
      QUAD_SECOND: begin sn = c0;  cs = -s0; end
      QUAD_THIRD:  begin sn = -s0; cs = -c0; end
      default:     begin sn = -c0; cs = s0;  end
    endcase
  endfunction

  function automatic logic signed [31:0] vertex_coord(input longint centre, input longint radius,
                                                       input int trig);
    longint sum;
    sum = centre + ((radius * trig + 64'sd16384) >>> 15);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  // pushes the 2*sides vertices that one star produces; the first one may be typed in
  task automatic predict_star_vertices(input star_t s, input bit use_first,
                                       input logic [31:0] first_x, input logic [31:0] first_y);
    int          sides, step, n;
    longint      cx, cy, r1, r2, rad;
    logic [15:0] ang;
    int          sn, cs;
    vertex_t     v;
    sides = s.points;
    if (sides < MIN_SIDES) sides = MIN_SIDES;
    if (sides > MAX_POINTS_DEF) sides = MAX_POINTS_DEF;
    cx = longint'($signed(s.cx));
    cy = longint'($signed(s.cy));
    r1 = longint'($signed(s.r_out));
    r2 = longint'($signed(s.r_in));
    if (r1 < longint'(MIN_OUTER)) r1 = longint'(MIN_OUTER);
    if (r2 < 0) r2 = 0;
    if (r2 > r1) r2 = r1;
    step = (65536 + sides / 2) / sides;
    n = 0;
    for (int k = 0; k < sides; k++) begin
      for (int pass = 0; pass < 2; pass++) begin
        ang = (pass != 0) ? s.a_in + 16'(k * step) : s.a_out + 16'(k * step);
        rad = (pass != 0) ? r2 : r1;
        sincos_q15({ang, 16'h0}, sn, cs);
        v.x     = vertex_coord(cx, rad, cs);
        v.y     = vertex_coord(cy, rad, sn);
        v.line  = (n != 0);
        v.close = (n == 2 * sides - 1);
        if (use_first && n == 0) begin
          v.x = first_x;
          v.y = first_y;
        end
        pending_vertices.push_back(v);
        n++;
      end
    end
  endtask

  task automatic send_star(input star_t s, input bit drain);
    if (drain && pending_vertices.size() != 0) begin
      in_tvalid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clk);
    end else if (!drain && !quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, s.a_in, s.a_out, s.r_in, s.r_out, s.cy, s.cx, s.points};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] random_coord();
    if ($urandom_range(0, 2) == 0) return $urandom;
    return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
  endfunction

  function automatic logic [31:0] random_radius();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return $urandom;
    if (pick == 1) return $urandom_range(0, 200);
    return $urandom_range(0, 32'h00FF_FFFF);
  endfunction

  function automatic star_t random_star();
    star_t s;
    s.points = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) :
                                             6'($urandom_range(0, 10));
    s.cx    = random_coord();
    s.cy    = random_coord();
    s.r_out = random_radius();
    s.r_in  = random_radius();
    s.a_out = 16'($urandom);
    s.a_in  = 16'($urandom);
    return s;
  endfunction

  // stimulus
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    quiet     = 1'b0;
    mismatch_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      send_star(DIRECTED_STARS[i].star, DIRECTED_STARS[i].drain);
      predict_star_vertices(DIRECTED_STARS[i].star, DIRECTED_STARS[i].check_first,
                            DIRECTED_STARS[i].first_x, DIRECTED_STARS[i].first_y);
    end

    for (int i = 0; i < RANDOM_STARS; i++) begin
      star_t s;
      s = random_star();
      quiet = (i >= QUIET_FROM);
      send_star(s, !quiet && $urandom_range(0, 24) == 0);
      predict_star_vertices(s, 1'b0, 32'h0, 32'h0);
    end
    in_tvalid <= 1'b0;

    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // output backpressure
  initial begin
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  // vertex checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_vertices.size() == 0) begin
        $error("vertex transaction with none expected: x=%h y=%h", out_tdata[31:0],
               out_tdata[63:32]);
        mismatch_count++;
      end else begin
        want_vertex = pending_vertices.pop_front();
        if (out_tdata[31:0] !== want_vertex.x) begin
          $error("vertex_x: expected %h, got %h", want_vertex.x, out_tdata[31:0]);
          mismatch_count++;
        end
        if (out_tdata[63:32] !== want_vertex.y) begin
          $error("vertex_y: expected %h, got %h", want_vertex.y, out_tdata[63:32]);
          mismatch_count++;
        end
        if (out_tuser !== want_vertex.line) begin
          $error("is_line: expected %b, got %b", want_vertex.line, out_tuser);
          mismatch_count++;
        end
        if (out_tlast !== want_vertex.close) begin
          $error("close_path: expected %b, got %b", want_vertex.close, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[filelist.f]
+incdir+src
src/spvg_pkg.sv
src/spvg_mul.sv
src/spvg_engine.sv
src/star_polygon_vertex_generator_unit.sv
dv/tb_top.sv
